>>> sv/rat_pkg.sv
// shared types, codes and defaults for the region address translator
package rat_pkg;

	localparam int MAX_REGIONS_DEF = 16;
	localparam int ADDR_WIDTH_DEF  = 32;
	localparam int FIELD_W         = 32;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_P2V   = 2'd1;
	localparam logic [1:0] OP_V2P   = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic       vld;
		logic [1:0] op;
		logic [1:0] status;
		logic       done;
	} tok_ctrl_t;

endpackage

>>> sv/rat_cell.sv
// one table slot of the region chain, passing the item token to the next slot
module rat_cell #(
	parameter int ADDR_WIDTH = rat_pkg::ADDR_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  rat_pkg::tok_ctrl_t       in_ctrl,
	input  logic [ADDR_WIDTH-1:0]    in_a,
	input  logic [ADDR_WIDTH-1:0]    in_b,
	input  logic [rat_pkg::FIELD_W-1:0] in_len,
	output rat_pkg::tok_ctrl_t       out_ctrl,
	output logic [ADDR_WIDTH-1:0]    out_a,
	output logic [ADDR_WIDTH-1:0]    out_b,
	output logic [rat_pkg::FIELD_W-1:0] out_len
);
	import rat_pkg::*;

	localparam int LW = (ADDR_WIDTH > FIELD_W) ? ADDR_WIDTH : FIELD_W;

	logic                  valid_q;
	logic [ADDR_WIDTH-1:0] vb_q;
	logic [ADDR_WIDTH-1:0] pb_q;
	logic [FIELD_W-1:0]    ln_q;

	tok_ctrl_t             ctrl_q;
	logic [ADDR_WIDTH-1:0] a_q;
	logic [ADDR_WIDTH-1:0] b_q;
	logic [FIELD_W-1:0]    len_q;

	logic [ADDR_WIDTH-1:0] src;
	logic [ADDR_WIDTH-1:0] dst;
	logic [ADDR_WIDTH:0]   diff_full;
	logic                  match;
	logic                  is_query;
	logic                  take_add;
	logic                  take_hit;
	tok_ctrl_t             ctrl_nxt;

	always_comb begin
		is_query  = (in_ctrl.op == OP_P2V) || (in_ctrl.op == OP_V2P);
		src       = (in_ctrl.op == OP_V2P) ? vb_q : pb_q;
		dst       = (in_ctrl.op == OP_V2P) ? pb_q : vb_q;
		diff_full = {1'b0, in_a} - {1'b0, src};
		// no borrow means addr >= base; window end compared at full precision
		match     = !diff_full[ADDR_WIDTH] &&
			(LW'(diff_full[ADDR_WIDTH-1:0]) < LW'(ln_q));
		take_add  = in_ctrl.vld && !in_ctrl.done && (in_ctrl.op == OP_ADD) && !valid_q;
		take_hit  = in_ctrl.vld && !in_ctrl.done && is_query && valid_q && match;
		ctrl_nxt      = in_ctrl;
		ctrl_nxt.done = in_ctrl.done || take_add || take_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ctrl.vld && (in_ctrl.op == OP_CLEAR)) begin
			valid_q <= 1'b0;
		end else if (take_add) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_add) begin
			vb_q <= in_a;
			pb_q <= in_b;
			ln_q <= in_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else begin
			ctrl_q <= ctrl_nxt;
		end
	end

	// on a hit the token carries offset and destination base onward
	always_ff @(posedge clk) begin
		a_q   <= take_hit ? diff_full[ADDR_WIDTH-1:0] : in_a;
		b_q   <= take_hit ? dst : in_b;
		len_q <= in_len;
	end

	assign out_ctrl = ctrl_q;
	assign out_a    = a_q;
	assign out_b    = b_q;
	assign out_len  = len_q;

endmodule

>>> sv/region_address_translator_top.sv
// region address translator: chain of table slots searched in insertion order
//
// channel   direction  handshake                 payload
// command   in         start && !busy            operation, virt_addr, phys_addr, region_size
// result    out        done (one-cycle strobe)   result_addr, hit, status
//
// one item enters per cycle; busy stays low, the slot chain is fully pipelined
// each result passes the input register, every slot register of the chain and the output register
// the token walks the chain slot by slot, so latency is set by the chain length
// reset empties the table at once through per-slot valid bits; no clearing pass
// results are strobed for one cycle and cannot be stalled by the receiver
module region_address_translator_top #(
	parameter int MAX_REGIONS = rat_pkg::MAX_REGIONS_DEF,
	parameter int ADDR_WIDTH  = rat_pkg::ADDR_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  operation,
	input  logic [rat_pkg::FIELD_W-1:0] virt_addr,
	input  logic [rat_pkg::FIELD_W-1:0] phys_addr,
	input  logic [rat_pkg::FIELD_W-1:0] region_size,
	output logic                        done,
	output logic [rat_pkg::FIELD_W-1:0] result_addr,
	output logic                        hit,
	output logic [1:0]                  status
);
	import rat_pkg::*;

	localparam int LW = (ADDR_WIDTH > FIELD_W) ? ADDR_WIDTH : FIELD_W;
	localparam int CW = $clog2(MAX_REGIONS + 1);

	logic [CW-1:0] count_q;
	logic          accept;
	logic          zero_sz;
	logic          full;
	logic [LW-1:0] va_ext;
	logic [LW-1:0] pa_ext;

	tok_ctrl_t             ctrl_nxt;
	tok_ctrl_t             ctrl_s1;
	logic [ADDR_WIDTH-1:0] a_s1;
	logic [ADDR_WIDTH-1:0] b_s1;
	logic [FIELD_W-1:0]    len_s1;

	tok_ctrl_t             chain_ctrl [MAX_REGIONS+1];
	logic [ADDR_WIDTH-1:0] chain_a    [MAX_REGIONS+1];
	logic [ADDR_WIDTH-1:0] chain_b    [MAX_REGIONS+1];
	logic [FIELD_W-1:0]    chain_len  [MAX_REGIONS+1];

	tok_ctrl_t             last_ctrl;
	logic [ADDR_WIDTH-1:0] last_sum;
	logic [LW-1:0]         res_ext;
	logic [FIELD_W-1:0]    res_nxt;
	logic                  hit_nxt;

	logic               done_q;
	logic [FIELD_W-1:0] res_q;
	logic               hit_q;
	logic [1:0]         status_q;

	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign zero_sz = (region_size == '0);
	assign full    = (count_q == CW'(MAX_REGIONS));
	assign va_ext  = LW'(virt_addr);
	assign pa_ext  = LW'(phys_addr);

	// count tracks the first free slot; adds land there in order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (operation == OP_CLEAR) begin
				count_q <= '0;
			end else if ((operation == OP_ADD) && !zero_sz && !full) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_comb begin
		ctrl_nxt.vld    = accept;
		ctrl_nxt.op     = operation;
		ctrl_nxt.status = ST_OK;
		ctrl_nxt.done   = 1'b0;
		if (operation == OP_ADD) begin
			// rejected adds travel already done so no slot takes them
			if (zero_sz) begin
				ctrl_nxt.status = ST_ZERO;
				ctrl_nxt.done   = 1'b1;
			end else if (full) begin
				ctrl_nxt.status = ST_FULL;
				ctrl_nxt.done   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1 <= ctrl_nxt;
		end
	end

	always_ff @(posedge clk) begin
		a_s1   <= (operation == OP_P2V) ? pa_ext[ADDR_WIDTH-1:0] : va_ext[ADDR_WIDTH-1:0];
		b_s1   <= pa_ext[ADDR_WIDTH-1:0];
		len_s1 <= region_size;
	end

	assign chain_ctrl[0] = ctrl_s1;
	assign chain_a[0]    = a_s1;
	assign chain_b[0]    = b_s1;
	assign chain_len[0]  = len_s1;

	for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
		rat_cell #(
			.ADDR_WIDTH(ADDR_WIDTH)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_ctrl (chain_ctrl[i]),
			.in_a    (chain_a[i]),
			.in_b    (chain_b[i]),
			.in_len  (chain_len[i]),
			.out_ctrl(chain_ctrl[i+1]),
			.out_a   (chain_a[i+1]),
			.out_b   (chain_b[i+1]),
			.out_len (chain_len[i+1])
		);
	end

	assign last_ctrl = chain_ctrl[MAX_REGIONS];
	assign last_sum  = chain_b[MAX_REGIONS] + chain_a[MAX_REGIONS];
	assign res_ext   = LW'(last_sum);

	always_comb begin
		res_nxt = '0;
		hit_nxt = 1'b0;
		if ((last_ctrl.op == OP_P2V) || (last_ctrl.op == OP_V2P)) begin
			if (last_ctrl.done) begin
				res_nxt = res_ext[FIELD_W-1:0];
				hit_nxt = 1'b1;
			end else begin
				res_nxt = FIELD_W'(LW'(chain_a[MAX_REGIONS]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= last_ctrl.vld;
		end
	end

	always_ff @(posedge clk) begin
		res_q    <= res_nxt;
		hit_q    <= hit_nxt;
		status_q <= last_ctrl.status;
	end

	assign done        = done_q;
	assign result_addr = res_q;
	assign hit         = done_q && hit_q;
	assign status      = status_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_REGIONS))
		else $error("region count beyond table size");

	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> (status == ST_OK))
		else $error("hit reported with non-ok status");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_ZERO || status == ST_FULL))
		else $error("undefined status code");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == OP_CLEAR) |=> (count_q == '0))
		else $error("clear did not empty the table");
`endif

endmodule
